>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the process tree table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PTT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("process tree table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PTT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("process tree table: next-cycle check failed");

`endif

>>> hw/rtl/ptt_pkg.sv
// Package with types, codes and command/status structs of the process tree table.
package ptt_pkg;

   localparam int NUM_ENTRIES_DEF = 128;
   localparam int KIND_W          = 2;
   localparam int ID_W            = 7;
   localparam int STATUS_W        = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INIT    = 2'd0,
      KIND_CREATE  = 2'd1,
      KIND_DESTROY = 2'd2,
      KIND_QUIT    = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_RST_CLR,
      S_IDLE,
      S_DISPATCH,
      S_CHK_EV,
      S_FIND_RD,
      S_FIND_EV,
      S_DCLR,
      S_MARK_RD,
      S_MARK_PAR,
      S_MARK_WR,
      S_FREE_RD,
      S_FREE_WR,
      S_CLEAR,
      S_RESP
   } state_type;

   // Table write data select
   typedef enum logic [1:0] {
      TW_NONE,
      TW_CLEAR,
      TW_ALLOC,
      TW_FREE
   } tbl_wr_type;

   // Mark memory write data select
   typedef enum logic [1:0] {
      DW_NONE,
      DW_INIT,
      DW_MARK
   } dm_wr_type;

   // Entry index counter operation
   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_CLR,
      IDX_ONE,
      IDX_INC
   } idx_op_type;

   typedef struct packed {
      logic       req_ready;
      logic       rd_en;
      logic       rd_pid;
      tbl_wr_type tbl_wr;
      dm_wr_type  dm_wr;
      idx_op_type idx_op;
      logic       grew_clr;
      logic       grew_set;
      logic       res_set;
      status_type res_status;
      logic       res_new;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic     req_valid;
      kind_type kind;
      logic     exists;
      logic     tbl_live;
      logic     idx_last;
      logic     mark_hit;
      logic     free_hit;
      logic     grew;
      logic     rsp_free;
   } stat_type;

endpackage

>>> hw/rtl/ptt_req_if.sv
// Request channel interface of the process tree table.
interface ptt_req_if;
   logic                      valid;
   logic                      ready;
   logic [ptt_pkg::KIND_W-1:0] kind;
   logic [ptt_pkg::ID_W-1:0]   parent_id;

   modport source (output valid, output kind, output parent_id, input ready);
   modport sink   (input valid, input kind, input parent_id, output ready);
endinterface

>>> hw/rtl/ptt_rsp_if.sv
// Response channel interface of the process tree table.
interface ptt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ptt_pkg::STATUS_W-1:0] status;
   logic [ptt_pkg::ID_W-1:0]     new_id;

   modport source (output valid, output status, output new_id, input ready);
   modport sink   (input valid, input status, input new_id, output ready);
endinterface

>>> hw/rtl/ptt_ctrl.sv
// Controller state machine of the process tree table.
module ptt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  ptt_pkg::stat_type stat,
   output ptt_pkg::cmd_type  cmd
);

   ptt_pkg::state_type state_ff;
   ptt_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::S_RST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptt_pkg::S_RST_CLR: begin
            if (stat.idx_last) state_in = ptt_pkg::S_IDLE;
         end
         ptt_pkg::S_IDLE: begin
            if (stat.req_valid) state_in = ptt_pkg::S_DISPATCH;
         end
         ptt_pkg::S_DISPATCH: begin
            if (stat.kind inside {ptt_pkg::KIND_INIT, ptt_pkg::KIND_QUIT}) begin
               state_in = ptt_pkg::S_CLEAR;
            end else begin
               state_in = ptt_pkg::S_CHK_EV;
            end
         end
         ptt_pkg::S_CHK_EV: begin
            if (!stat.exists) begin
               state_in = ptt_pkg::S_RESP;
            end else if (stat.kind == ptt_pkg::KIND_CREATE) begin
               state_in = ptt_pkg::S_FIND_RD;
            end else begin
               state_in = ptt_pkg::S_DCLR;
            end
         end
         ptt_pkg::S_FIND_RD: state_in = ptt_pkg::S_FIND_EV;
         ptt_pkg::S_FIND_EV: begin
            if (!stat.tbl_live || stat.idx_last) begin
               state_in = ptt_pkg::S_RESP;
            end else begin
               state_in = ptt_pkg::S_FIND_RD;
            end
         end
         ptt_pkg::S_DCLR: begin
            if (stat.idx_last) state_in = ptt_pkg::S_MARK_RD;
         end
         ptt_pkg::S_MARK_RD:  state_in = ptt_pkg::S_MARK_PAR;
         ptt_pkg::S_MARK_PAR: state_in = ptt_pkg::S_MARK_WR;
         ptt_pkg::S_MARK_WR: begin
            if (!stat.idx_last) begin
               state_in = ptt_pkg::S_MARK_RD;
            end else if (stat.grew || stat.mark_hit) begin
               state_in = ptt_pkg::S_MARK_RD;
            end else begin
               state_in = ptt_pkg::S_FREE_RD;
            end
         end
         ptt_pkg::S_FREE_RD: state_in = ptt_pkg::S_FREE_WR;
         ptt_pkg::S_FREE_WR: begin
            if (stat.idx_last) begin
               state_in = ptt_pkg::S_RESP;
            end else begin
               state_in = ptt_pkg::S_FREE_RD;
            end
         end
         ptt_pkg::S_CLEAR: begin
            if (stat.idx_last) state_in = ptt_pkg::S_RESP;
         end
         ptt_pkg::S_RESP: begin
            if (stat.rsp_free) state_in = ptt_pkg::S_IDLE;
         end
         default: state_in = ptt_pkg::S_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ptt_pkg::S_RST_CLR: begin
            cmd.tbl_wr = ptt_pkg::TW_CLEAR;
            cmd.idx_op = stat.idx_last ? ptt_pkg::IDX_CLR : ptt_pkg::IDX_INC;
         end
         ptt_pkg::S_IDLE: begin
            cmd.req_ready = 1'b1;
         end
         ptt_pkg::S_DISPATCH: begin
            // look up the named entry; the scan index starts at zero, and a create moves it to one
            cmd.rd_en  = 1'b1;
            cmd.rd_pid = 1'b1;
            cmd.idx_op = ptt_pkg::IDX_CLR;
         end
         ptt_pkg::S_CHK_EV: begin
            if (!stat.exists) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ptt_pkg::ST_MISSING;
            end else if (stat.kind == ptt_pkg::KIND_CREATE) begin
               cmd.idx_op = ptt_pkg::IDX_ONE;
            end
         end
         ptt_pkg::S_FIND_RD: begin
            cmd.rd_en = 1'b1;
         end
         ptt_pkg::S_FIND_EV: begin
            if (!stat.tbl_live) begin
               cmd.tbl_wr     = ptt_pkg::TW_ALLOC;
               cmd.res_set    = 1'b1;
               cmd.res_status = ptt_pkg::ST_OK;
               cmd.res_new    = 1'b1;
            end else if (stat.idx_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ptt_pkg::ST_FULL;
            end else begin
               cmd.idx_op = ptt_pkg::IDX_INC;
            end
         end
         ptt_pkg::S_DCLR: begin
            cmd.dm_wr = ptt_pkg::DW_INIT;
            if (stat.idx_last) begin
               cmd.idx_op   = ptt_pkg::IDX_CLR;
               cmd.grew_clr = 1'b1;
            end else begin
               cmd.idx_op = ptt_pkg::IDX_INC;
            end
         end
         ptt_pkg::S_MARK_RD: begin
            cmd.rd_en = 1'b1;
         end
         ptt_pkg::S_MARK_PAR: begin
            // parent mark read runs in the datapath every cycle
         end
         ptt_pkg::S_MARK_WR: begin
            if (stat.mark_hit) begin
               cmd.dm_wr    = ptt_pkg::DW_MARK;
               cmd.grew_set = 1'b1;
            end
            if (stat.idx_last) begin
               cmd.idx_op   = ptt_pkg::IDX_CLR;
               cmd.grew_clr = 1'b1;
            end else begin
               cmd.idx_op = ptt_pkg::IDX_INC;
            end
         end
         ptt_pkg::S_FREE_RD: begin
            cmd.rd_en = 1'b1;
         end
         ptt_pkg::S_FREE_WR: begin
            if (stat.free_hit) cmd.tbl_wr = ptt_pkg::TW_FREE;
            if (stat.idx_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ptt_pkg::ST_OK;
            end else begin
               cmd.idx_op = ptt_pkg::IDX_INC;
            end
         end
         ptt_pkg::S_CLEAR: begin
            cmd.tbl_wr = ptt_pkg::TW_CLEAR;
            if (stat.idx_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ptt_pkg::ST_OK;
            end else begin
               cmd.idx_op = ptt_pkg::IDX_INC;
            end
         end
         ptt_pkg::S_RESP: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

>>> hw/rtl/ptt_datapath.sv
// Datapath of the process tree table: entry memory, mark memory, index and result registers.
module ptt_datapath #(
   parameter int NUM_ENTRIES = ptt_pkg::NUM_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   ptt_req_if.sink           req,
   ptt_rsp_if.source         rsp,
   input  ptt_pkg::cmd_type  cmd,
   output ptt_pkg::stat_type stat
);

   localparam int IW = $clog2(NUM_ENTRIES);
   localparam int CW = (IW > ptt_pkg::ID_W) ? IW + 1 : ptt_pkg::ID_W + 1;

   // entry word: live bit on top, parent index below
   logic [IW:0] tbl_mem [NUM_ENTRIES];
   logic        dm_mem  [NUM_ENTRIES];

   ptt_pkg::kind_type        kind_ff;
   logic [ptt_pkg::ID_W-1:0] pid_ff;
   logic [IW-1:0]            idx_ff;
   logic [IW-1:0]            idx_in;
   logic [IW:0]              tbl_q_ff;
   logic                     dm_a_ff;
   logic                     dm_b_ff;
   logic                     grew_ff;
   ptt_pkg::status_type      res_status_ff;
   logic [ptt_pkg::ID_W-1:0] res_new_ff;
   logic                     rsp_valid_ff;
   ptt_pkg::status_type      out_status_ff;
   logic [ptt_pkg::ID_W-1:0] out_new_ff;

   logic [IW-1:0] pid_idx;
   logic [IW-1:0] rd_addr;
   logic          in_range;
   logic          at_top;
   logic          idx_last;
   logic [IW:0]   tbl_wdata;
   logic          dm_wdata;

   assign pid_idx  = IW'(pid_ff);
   assign in_range = CW'(pid_ff) < CW'(NUM_ENTRIES);
   assign at_top   = (idx_ff == pid_idx);
   assign idx_last = (idx_ff == IW'(NUM_ENTRIES - 1));
   assign rd_addr  = cmd.rd_pid ? pid_idx : idx_ff;

   // Request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= ptt_pkg::KIND_QUIT;
      end else if (req.valid && cmd.req_ready) begin
         kind_ff <= ptt_pkg::kind_type'(req.kind);
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && cmd.req_ready) begin
         pid_ff <= req.parent_id;
      end
   end

   // Entry index counter
   always_comb begin
      case (cmd.idx_op)
         ptt_pkg::IDX_CLR: idx_in = '0;
         ptt_pkg::IDX_ONE: idx_in = IW'(1);
         ptt_pkg::IDX_INC: idx_in = idx_ff + IW'(1);
         default:          idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // Write data selection
   always_comb begin
      case (cmd.tbl_wr)
         ptt_pkg::TW_CLEAR: tbl_wdata = {(kind_ff == ptt_pkg::KIND_INIT) && (idx_ff == '0),
                                         {IW{1'b0}}};
         ptt_pkg::TW_ALLOC: tbl_wdata = {1'b1, pid_idx};
         ptt_pkg::TW_FREE:  tbl_wdata = {1'b0, tbl_q_ff[IW-1:0]};
         default:           tbl_wdata = '0;
      endcase
   end

   always_comb begin
      case (cmd.dm_wr)
         ptt_pkg::DW_INIT: dm_wdata = at_top;
         ptt_pkg::DW_MARK: dm_wdata = 1'b1;
         default:          dm_wdata = 1'b0;
      endcase
   end

   // Entry memory
   always_ff @(posedge clock) begin
      if (cmd.tbl_wr != ptt_pkg::TW_NONE) begin
         tbl_mem[idx_ff] <= tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         tbl_q_ff <= tbl_mem[rd_addr];
      end
   end

   // Mark memory: one write port, a read at the scan index and one at the parent
   always_ff @(posedge clock) begin
      if (cmd.dm_wr != ptt_pkg::DW_NONE) begin
         dm_mem[idx_ff] <= dm_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         dm_a_ff <= dm_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      dm_b_ff <= dm_mem[tbl_q_ff[IW-1:0]];
   end

   // Pass growth flag; clear wins so a new pass starts clean
   always_ff @(posedge clock) begin
      if (reset) begin
         grew_ff <= 1'b0;
      end else if (cmd.grew_clr) begin
         grew_ff <= 1'b0;
      end else if (cmd.grew_set) begin
         grew_ff <= 1'b1;
      end
   end

   // Result held until the output register is free
   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_new_ff    <= cmd.res_new ? ptt_pkg::ID_W'(idx_ff) : '0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_status_ff <= res_status_ff;
         out_new_ff    <= res_new_ff;
      end
   end

   assign req.ready  = cmd.req_ready;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = out_status_ff;
   assign rsp.new_id = out_new_ff;

   // Status to the controller
   assign stat.req_valid = req.valid;
   assign stat.kind      = kind_ff;
   assign stat.exists    = in_range && tbl_q_ff[IW];
   assign stat.tbl_live  = tbl_q_ff[IW];
   assign stat.idx_last  = idx_last;
   assign stat.mark_hit  = !at_top && tbl_q_ff[IW] && !dm_a_ff && dm_b_ff;
   assign stat.free_hit  = !at_top && dm_a_ff;
   assign stat.grew      = grew_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp.ready;

endmodule

>>> hw/rtl/process_tree_table.sv
// Init/quit clear every entry; create probes slots upward from index 1 for a free one;
// destroy clears the marks, runs mark passes (at most tree depth + 1), then frees marked entries.
// One request is worked at a time.
// A new request is taken while the previous response waits in the output register.
// Reset is synchronous; after it a clearing pass over all entries empties the table
// before the first request is taken.
`include "assert_macros.svh"

module process_tree_table #(
   parameter int NUM_ENTRIES = ptt_pkg::NUM_ENTRIES_DEF
) (
   input logic       clock,
   input logic       reset,
   ptt_req_if.sink   req_chan,
   ptt_rsp_if.source rsp_chan
);

   ptt_pkg::cmd_type  cmd;
   ptt_pkg::stat_type stat;

   // Controller
   ptt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Datapath
   ptt_datapath #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .cmd   (cmd),
      .stat  (stat)
   );

   // Checks
   `PTT_ASSERT_NXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `PTT_ASSERT_IMP(a_no_overwrite, clock, reset, !stat.rsp_free, !cmd.rsp_load)
   `PTT_ASSERT_IMP(a_id_only_on_ok, clock, reset,
                   rsp_chan.valid && (rsp_chan.status != ptt_pkg::ST_OK), rsp_chan.new_id == '0)

endmodule

>>> test/process_tree_table_test.sv
// Testbench for process_tree_table: random and directed requests checked against a tree model.
`timescale 1ns / 1ps

module process_tree_table_test;
   import ptt_pkg::*;

   localparam int ENTRIES     = NUM_ENTRIES_DEF;
   localparam int RANDOM_REQS = 349;
   // A destroy over a full-depth chain is the slowest request; the limit allows several times its length.
   localparam int IDLE_LIMIT  = 200000;
   localparam int DRAIN_WAIT  = 300;
   localparam int LONG_HOLD   = 400;

   typedef struct packed {
      status_type     status;
      logic [ID_W-1:0] new_id;
   } answer_type;

   // Tree model of the table plus the queue of answers still owed by the block
   class tree_scoreboard;
      bit              live [ENTRIES];
      logic [ID_W-1:0] up   [ENTRIES];
      answer_type      owed [$];
      int              errors;

      function new();
         foreach (live[i]) begin
            live[i] = 1'b0;
            up[i]   = '0;
         end
         errors = 0;
      endfunction

      function bit any_live();
         foreach (live[i])
            if (live[i]) return 1'b1;
         return 1'b0;
      endfunction

      // Random live entry, or any index when the table is empty
      function logic [ID_W-1:0] pick_live();
         int ids [$];
         foreach (live[i])
            if (live[i]) ids.push_back(i);
         if (ids.size() == 0) return ID_W'($urandom_range(0, 127));
         return ID_W'(ids[$urandom_range(0, ids.size() - 1)]);
      endfunction

      // Free every descendant of top; top itself survives
      function void prune(int top);
         bit doomed [ENTRIES];
         bit grew;
         foreach (doomed[i]) doomed[i] = 1'b0;
         doomed[top] = 1'b1;
         grew = 1'b1;
         while (grew) begin
            grew = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (i != top && live[i] && !doomed[i] && doomed[up[i]]) begin
                  doomed[i] = 1'b1;
                  grew      = 1'b1;
               end
            end
         end
         for (int i = 0; i < ENTRIES; i++)
            if (i != top && doomed[i]) live[i] = 1'b0;
      endfunction

      // Apply one accepted request to the model and queue its answer
      function void note_request(kind_type kind, logic [ID_W-1:0] pid);
         answer_type ans;
         bit         present;
         int         slot;
         ans.status = ST_OK;
         ans.new_id = '0;
         present    = (pid < ENTRIES) && live[pid];
         case (kind)
            KIND_INIT: begin
               foreach (live[i]) live[i] = 1'b0;
               live[0] = 1'b1;
               up[0]   = '0;
            end
            KIND_CREATE: begin
               if (!present) begin
                  ans.status = ST_MISSING;
               end else begin
                  slot = 1;
                  while (slot < ENTRIES && live[slot]) slot++;
                  if (slot >= ENTRIES) begin
                     ans.status = ST_FULL;
                  end else begin
                     live[slot] = 1'b1;
                     up[slot]   = pid;
                     ans.new_id = ID_W'(slot);
                  end
               end
            end
            KIND_DESTROY: begin
               if (!present) ans.status = ST_MISSING;
               else prune(pid);
            end
            default: begin
               foreach (live[i]) live[i] = 1'b0;
            end
         endcase
         owed.push_back(ans);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(logic [STATUS_W-1:0] status, logic [ID_W-1:0] new_id);
         answer_type want;
         if (owed.size() == 0) begin
            report($sformatf("unexpected response status=%0d new_id=%0d", status, new_id));
         end else begin
            want = owed.pop_front();
            if (status !== want.status)
               report($sformatf("status %0d, expected %0d", status, want.status));
            if (new_id !== want.new_id)
               report($sformatf("new_id %0d, expected %0d", new_id, want.new_id));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   sent;

   tree_scoreboard sb = new();

   ptt_req_if req_chan ();
   ptt_rsp_if rsp_chan ();

   process_tree_table u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock generation
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   // Offer one request after a random gap and hold it until accepted
   task send_request(kind_type kind, logic [ID_W-1:0] pid);
      int gap;
      gap = (sent % 100 >= 75) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= kind;
      req_chan.parent_id <= pid;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sb.note_request(kind, pid);
      sent++;
   endtask

   // Response side: random stalls, one long hold-off, and stretches with none
   initial begin : receiver
      int stall;
      int got;
      got            = 0;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (got == 40) stall = LONG_HOLD;
         else if (got % 100 >= 60) stall = 0;
         else stall = $urandom_range(0, 7);
         if (stall > 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         sb.check_response(rsp_chan.status, rsp_chan.new_id);
         got++;
      end
   end

   // Watchdog on cycles without any accepted request or response
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle = 0;
         else
            idle++;
      end
      $display("FAILURE");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      int       roll;
      bit       growing;
      kind_type kind;
      sent               = 0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_INIT;
      req_chan.parent_id = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Commands on an empty table, then a small tree
      send_request(KIND_CREATE, 7'd0);
      send_request(KIND_DESTROY, 7'd0);
      send_request(KIND_QUIT, 7'd0);
      send_request(KIND_INIT, 7'd127);
      send_request(KIND_CREATE, 7'd0);
      send_request(KIND_CREATE, 7'd1);
      send_request(KIND_CREATE, 7'd2);
      send_request(KIND_CREATE, 7'd0);
      send_request(KIND_CREATE, 7'd127);
      send_request(KIND_DESTROY, 7'd127);
      // Subtree removal, then reuse of the lowest hole
      send_request(KIND_DESTROY, 7'd1);
      send_request(KIND_CREATE, 7'd4);
      // Root destroy frees all others despite its self link
      send_request(KIND_DESTROY, 7'd0);
      send_request(KIND_CREATE, 7'd0);
      // Init over a live table
      send_request(KIND_CREATE, 7'd1);
      send_request(KIND_INIT, 7'd0);
      send_request(KIND_CREATE, 7'd1);
      send_request(KIND_QUIT, 7'd85);
      send_request(KIND_DESTROY, 7'd0);
      send_request(KIND_INIT, 7'd0);

      // Fill the table as one deep chain, hit full, then tear it down
      for (int p = 0; p < ENTRIES - 1; p++)
         send_request(KIND_CREATE, ID_W'(p));
      send_request(KIND_CREATE, 7'd5);
      send_request(KIND_CREATE, 7'd126);
      send_request(KIND_DESTROY, 7'd100);
      send_request(KIND_DESTROY, 7'd0);

      // Random part; the middle stretch mostly grows the tree until it is full
      for (int n = 0; n < RANDOM_REQS; n++) begin
         roll    = $urandom_range(0, 99);
         growing = (n >= 150 && n < 300);
         if (!sb.any_live() && roll < 70)
            send_request(KIND_INIT, ID_W'($urandom_range(0, 127)));
         else if (roll < 5) begin
            kind = kind_type'($urandom_range(0, 3));
            send_request(kind, ID_W'($urandom_range(0, 127)));
         end else if (growing || roll < 65)
            send_request(KIND_CREATE, sb.pick_live());
         else if (roll < 78)
            send_request(KIND_DESTROY, sb.pick_live());
         else if (roll < 84)
            send_request(KIND_CREATE, ID_W'($urandom_range(0, 127)));
         else if (roll < 90)
            send_request(KIND_DESTROY, ID_W'($urandom_range(0, 127)));
         else if (roll < 95)
            send_request(KIND_INIT, ID_W'($urandom_range(0, 127)));
         else
            send_request(KIND_QUIT, ID_W'($urandom_range(0, 127)));
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Drain, then watch a while for stray responses
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
